// ===== design/rpc_pkg.sv =====
// ---------------------------------------------------------------------------
// Rectangle polygon clipper package
// Shared types, register indexes and the half-plane helper functions.
// ---------------------------------------------------------------------------
package rpc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NUM_STAGES  = 4;
    localparam int STAGE_W     = $clog2(NUM_STAGES) + 1;
    localparam int SIDX_W      = $clog2(NUM_STAGES);
    localparam int ITER_W      = $clog2(COORD_WIDTH);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [COORD_WIDTH-1:0]        mag_t;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    localparam logic [SIDX_W-1:0] STG_LEFT   = SIDX_W'(0);
    localparam logic [SIDX_W-1:0] STG_BOTTOM = SIDX_W'(1);
    localparam logic [SIDX_W-1:0] STG_RIGHT  = SIDX_W'(2);
    localparam logic [SIDX_W-1:0] STG_TOP    = SIDX_W'(3);

    typedef struct packed {
        coord_t left;
        coord_t right;
        coord_t bottom;
        coord_t top;
    } bounds_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } vert_t;

    // Operands of one edge crossing, already reduced to magnitudes.
    typedef struct packed {
        mag_t   a;
        mag_t   m;
        mag_t   c;
        logic   neg;
        coord_t base;
        coord_t bnd;
        logic   axis_y;
    } xreq_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_STAGE,
        B_DIV,
        B_NEXT,
        B_CLOSE,
        B_FINAL
    } back_state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV
    } div_state_t;

    function automatic logic inside_of(logic [SIDX_W-1:0] s, bounds_t bd,
                                       coord_t x, coord_t y);
        logic r;
        case (s)
            STG_LEFT:   r = (x >= bd.left);
            STG_BOTTOM: r = (y >= bd.bottom);
            STG_RIGHT:  r = (x <= bd.right);
            default:    r = (y <= bd.top);
        endcase
        return r;
    endfunction

    function automatic xreq_t make_xreq(logic [SIDX_W-1:0] s, bounds_t bd,
                                        coord_t px, coord_t py,
                                        coord_t vx, coord_t vy);
        xreq_t r;
        coord_t b;
        coord_t pa;
        coord_t va;
        coord_t po;
        coord_t vo;
        logic signed [COORD_WIDTH:0] num;
        logic signed [COORD_WIDTH:0] den;
        logic signed [COORD_WIDTH:0] d;
        logic signed [COORD_WIDTH:0] an;
        logic signed [COORD_WIDTH:0] ac;
        logic signed [COORD_WIDTH:0] am;
        case (s)
            STG_LEFT:   b = bd.left;
            STG_BOTTOM: b = bd.bottom;
            STG_RIGHT:  b = bd.right;
            default:    b = bd.top;
        endcase
        r.axis_y = s[0];
        pa  = r.axis_y ? py : px;
        va  = r.axis_y ? vy : vx;
        po  = r.axis_y ? px : py;
        vo  = r.axis_y ? vx : vy;
        num = {b[COORD_WIDTH-1], b} - {pa[COORD_WIDTH-1], pa};
        den = {va[COORD_WIDTH-1], va} - {pa[COORD_WIDTH-1], pa};
        d   = {vo[COORD_WIDTH-1], vo} - {po[COORD_WIDTH-1], po};
        an  = num[COORD_WIDTH] ? -num : num;
        ac  = den[COORD_WIDTH] ? -den : den;
        am  = d[COORD_WIDTH] ? -d : d;
        // The ratio is clamped to one, so the crossing stays on the edge.
        r.a    = (an > ac) ? ac[COORD_WIDTH-1:0] : an[COORD_WIDTH-1:0];
        r.c    = ac[COORD_WIDTH-1:0];
        r.m    = am[COORD_WIDTH-1:0];
        r.neg  = d[COORD_WIDTH];
        r.base = po;
        r.bnd  = b;
        return r;
    endfunction

endpackage

// ===== design/rpc_xunit.sv =====
// ---------------------------------------------------------------------------
// Crossing unit
// Multiplies the offset by the edge run, then divides by the edge span two
// quotient bits a cycle, and assembles the crossing point.
// ---------------------------------------------------------------------------
module rpc_xunit
    import rpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  xreq_t  req,
    output logic   done,
    output coord_t x,
    output coord_t y
);

    localparam int PW = 2 * COORD_WIDTH;

    div_state_t              state_reg, state_next;
    xreq_t                   req_reg, req_next;
    logic [PW-1:0]           dq_reg, dq_next;
    mag_t                    rem_reg, rem_next;
    logic [ITER_W-1:0]       cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    coord_t                  x_reg, x_next;
    coord_t                  y_reg, y_next;

    logic [PW-1:0]           st_dq;
    mag_t                    st_rem;
    logic [COORD_WIDTH:0]    trial;
    mag_t                    quot;
    logic signed [COORD_WIDTH:0] res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    // Two restoring division steps.
    always_comb
    begin
        st_dq  = dq_reg;
        st_rem = rem_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial = {st_rem, st_dq[PW-1]};
            st_dq = {st_dq[PW-2:0], 1'b0};
            if (trial >= {1'b0, req_reg.c})
            begin
                trial    = trial - {1'b0, req_reg.c};
                st_dq[0] = 1'b1;
            end
            st_rem = trial[COORD_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        quot       = (req_reg.c == '0) ? '0 : st_dq[COORD_WIDTH-1:0];
        res        = {req_reg.base[COORD_WIDTH-1], req_reg.base}
                   + (req_reg.neg ? -{1'b0, quot} : {1'b0, quot});
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = D_MUL;
                end
            end
            D_MUL:
            begin
                dq_next    = req_reg.a * req_reg.m;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = D_DIV;
            end
            D_DIV:
            begin
                dq_next  = st_dq;
                rem_next = st_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(COORD_WIDTH - 1))
                begin
                    x_next     = req_reg.axis_y ? res[COORD_WIDTH-1:0] : req_reg.bnd;
                    y_next     = req_reg.axis_y ? req_reg.bnd : res[COORD_WIDTH-1:0];
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;

endmodule

// ===== design/rpc_front.sv =====
// ---------------------------------------------------------------------------
// Clipper front end
// Holds the clip bounds and queues incoming vertices for the back end.
// ---------------------------------------------------------------------------
module rpc_front
    import rpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vert_valid,
    output logic       vert_ready,
    input  coord_t     vert_x,
    input  coord_t     vert_y,
    input  logic       vert_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  coord_t     cfg_data,
    output bounds_t    bounds,
    output logic       q_valid,
    output vert_t      q_item,
    input  logic       q_pop
);

    bounds_t     bounds_reg;
    vert_t       ent_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;

    assign vert_ready = (count_reg != 2'd2);
    assign cfg_ready  = 1'b1;
    assign push       = vert_valid && vert_ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = ent_reg[rd_ptr_reg];
    assign bounds     = bounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.left   <= COORD_WIDTH'(20);
            bounds_reg.right  <= COORD_WIDTH'(120);
            bounds_reg.bottom <= COORD_WIDTH'(20);
            bounds_reg.top    <= COORD_WIDTH'(120);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LEFT:   bounds_reg.left   <= cfg_data;
                REG_RIGHT:  bounds_reg.right  <= cfg_data;
                REG_BOTTOM: bounds_reg.bottom <= cfg_data;
                REG_TOP:    bounds_reg.top    <= cfg_data;
                default:    bounds_reg.top    <= bounds_reg.top;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= '{x: vert_x, y: vert_y, last: vert_last};
        end
    end

endmodule

// ===== design/rpc_back.sv =====
// ---------------------------------------------------------------------------
// Clipper back end
// Walks each vertex through the four half-plane stages, closes the polygon
// on the last vertex and drives the output register.
// ---------------------------------------------------------------------------
module rpc_back
    import rpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  bounds_t bounds,
    input  logic    q_valid,
    input  vert_t   q_item,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output coord_t  out_x,
    output coord_t  out_y,
    output logic    out_last,
    output logic    out_empty
);

    back_state_t             state_reg, state_next;
    coord_t                  cur_x_reg, cur_x_next;
    coord_t                  cur_y_reg, cur_y_next;
    logic [STAGE_W-1:0]      cur_s_reg, cur_s_next;
    logic [STAGE_W-1:0]      close_reg, close_next;
    logic                    last_reg, last_next;
    logic [NUM_STAGES-1:0]   pend_reg, pend_next;
    coord_t                  pend_x_reg [NUM_STAGES];
    coord_t                  pend_x_next [NUM_STAGES];
    coord_t                  pend_y_reg [NUM_STAGES];
    coord_t                  pend_y_next [NUM_STAGES];
    coord_t                  first_x_reg [NUM_STAGES];
    coord_t                  first_x_next [NUM_STAGES];
    coord_t                  first_y_reg [NUM_STAGES];
    coord_t                  first_y_next [NUM_STAGES];
    coord_t                  prev_x_reg [NUM_STAGES];
    coord_t                  prev_x_next [NUM_STAGES];
    coord_t                  prev_y_reg [NUM_STAGES];
    coord_t                  prev_y_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]   has_reg, has_next;
    logic                    any_reg, any_next;
    coord_t                  held_x_reg, held_x_next;
    coord_t                  held_y_reg, held_y_next;
    logic                    out_valid_reg, out_valid_next;
    coord_t                  out_x_reg, out_x_next;
    coord_t                  out_y_reg, out_y_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_empty_reg, out_empty_next;

    logic [SIDX_W-1:0]       sidx;
    logic [SIDX_W-1:0]       psel;
    logic                    vin;
    logic                    pin;
    logic                    fin;
    logic                    slot_free;
    logic                    x_start;
    xreq_t                   x_req;
    logic                    x_done;
    coord_t                  x_x;
    coord_t                  x_y;

    rpc_xunit u_xunit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (x_start),
        .req   (x_req),
        .done  (x_done),
        .x     (x_x),
        .y     (x_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cur_s_reg     <= '0;
            close_reg     <= '0;
            last_reg      <= 1'b0;
            pend_reg      <= '0;
            has_reg       <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_s_reg     <= cur_s_next;
            close_reg     <= close_next;
            last_reg      <= last_next;
            pend_reg      <= pend_next;
            has_reg       <= has_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        first_x_reg   <= first_x_next;
        first_y_reg   <= first_y_next;
        prev_x_reg    <= prev_x_next;
        prev_y_reg    <= prev_y_next;
        held_x_reg    <= held_x_next;
        held_y_reg    <= held_y_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign sidx      = (state_reg == B_CLOSE) ? close_reg[SIDX_W-1:0]
                                              : cur_s_reg[SIDX_W-1:0];
    assign vin       = inside_of(sidx, bounds, cur_x_reg, cur_y_reg);
    assign pin       = inside_of(sidx, bounds, prev_x_reg[sidx], prev_y_reg[sidx]);
    assign fin       = inside_of(sidx, bounds, first_x_reg[sidx], first_y_reg[sidx]);
    assign slot_free = !out_valid_reg || out_ready;

    // The deepest pending vertex is resumed first, as in a depth-first walk.
    always_comb
    begin
        psel = '0;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (pend_reg[i])
            begin
                psel = SIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cur_s_next     = cur_s_reg;
        close_next     = close_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        pend_x_next    = pend_x_reg;
        pend_y_next    = pend_y_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        has_next       = has_reg;
        any_next       = any_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        q_pop          = 1'b0;
        x_start        = 1'b0;
        x_req          = make_xreq(sidx, bounds, prev_x_reg[sidx], prev_y_reg[sidx],
                                   cur_x_reg, cur_y_reg);

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_x_next = q_item.x;
                    cur_y_next = q_item.y;
                    last_next  = q_item.last;
                    cur_s_next = '0;
                    state_next = B_STAGE;
                end
            end
            B_STAGE:
            begin
                if (cur_s_reg == STAGE_W'(NUM_STAGES))
                begin
                    // A surviving vertex pushes the held one out.
                    if (!any_reg || slot_free)
                    begin
                        if (any_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_x_next     = held_x_reg;
                            out_y_next     = held_y_reg;
                            out_last_next  = 1'b0;
                            out_empty_next = 1'b0;
                        end
                        held_x_next = cur_x_reg;
                        held_y_next = cur_y_reg;
                        any_next    = 1'b1;
                        state_next  = B_NEXT;
                    end
                end
                else
                begin
                    prev_x_next[sidx] = cur_x_reg;
                    prev_y_next[sidx] = cur_y_reg;
                    if (!has_reg[sidx])
                    begin
                        has_next[sidx]     = 1'b1;
                        first_x_next[sidx] = cur_x_reg;
                        first_y_next[sidx] = cur_y_reg;
                    end
                    if (has_reg[sidx] && (pin != vin))
                    begin
                        x_start           = 1'b1;
                        pend_next[sidx]   = vin;
                        pend_x_next[sidx] = cur_x_reg;
                        pend_y_next[sidx] = cur_y_reg;
                        cur_s_next        = cur_s_reg + 1'b1;
                        state_next        = B_DIV;
                    end
                    else if (vin)
                    begin
                        cur_s_next = cur_s_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = B_NEXT;
                    end
                end
            end
            B_DIV:
            begin
                if (x_done)
                begin
                    cur_x_next = x_x;
                    cur_y_next = x_y;
                    state_next = B_STAGE;
                end
            end
            B_NEXT:
            begin
                if (pend_reg != '0)
                begin
                    pend_next[psel] = 1'b0;
                    cur_x_next      = pend_x_reg[psel];
                    cur_y_next      = pend_y_reg[psel];
                    cur_s_next      = {1'b0, psel} + 1'b1;
                    state_next      = B_STAGE;
                end
                else if (last_reg)
                begin
                    state_next = B_CLOSE;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_CLOSE:
            begin
                if (close_reg == STAGE_W'(NUM_STAGES))
                begin
                    state_next = B_FINAL;
                end
                else
                begin
                    has_next[sidx] = 1'b0;
                    close_next     = close_reg + 1'b1;
                    if (has_reg[sidx] && (pin != fin))
                    begin
                        x_start    = 1'b1;
                        x_req      = make_xreq(sidx, bounds,
                                               prev_x_reg[sidx], prev_y_reg[sidx],
                                               first_x_reg[sidx], first_y_reg[sidx]);
                        cur_s_next = close_reg + 1'b1;
                        state_next = B_DIV;
                    end
                end
            end
            B_FINAL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = any_reg ? held_x_reg : '0;
                    out_y_next     = any_reg ? held_y_reg : '0;
                    out_last_next  = 1'b1;
                    out_empty_next = !any_reg;
                    any_next       = 1'b0;
                    last_next      = 1'b0;
                    close_next     = '0;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;
    assign out_empty = out_empty_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> (pend_reg == '0))
        else $error("pending vertex left over between input vertices");

    a_final_stages_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FINAL) |-> (has_reg == '0))
        else $error("stage still holds a first vertex when the polygon closes");

    a_final_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FINAL && slot_free) |=> (!any_reg && out_valid_reg && out_last_reg))
        else $error("closing transaction did not go out correctly");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        x_done |-> (state_reg == B_DIV))
        else $error("crossing result arrived while the sequencer was not waiting");

endmodule

// ===== design/rect_polygon_clipper.sv =====
// ---------------------------------------------------------------------------
// Rectangle polygon clipper
// Sutherland-Hodgman clipping of a streamed polygon against a rectangle.
// ---------------------------------------------------------------------------
// One vertex at a time: it leaves the queue in B_IDLE, visits B_STAGE once per
// stage it enters (the output hand-off counts as a fifth) and finishes in B_NEXT.
// Each edge crossing waits in B_DIV on the shared multiply-and-divide unit, then
// walks on through the later stages. The last vertex closes the stages in B_CLOSE
// with any closing crossings, then B_FINAL sends the final transaction.
// Reset clears all stage state and loads the bounds 20, 120, 20, 120.
module rect_polygon_clipper
    import rpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vert_valid,
    output logic       vert_ready,
    input  coord_t     vert_x,
    input  coord_t     vert_y,
    input  logic       vert_last,
    output logic       out_valid,
    input  logic       out_ready,
    output coord_t     out_x,
    output coord_t     out_y,
    output logic       out_last,
    output logic       out_empty,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  coord_t     cfg_data
);

    bounds_t bounds;
    logic    q_valid;
    vert_t   q_item;
    logic    q_pop;

    rpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .vert_x     (vert_x),
        .vert_y     (vert_y),
        .vert_last  (vert_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .bounds     (bounds),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    rpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bounds    (bounds),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_last  (out_last),
        .out_empty (out_empty)
    );

endmodule

// ===== verif/rpc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rectangle polygon clipper checker
// Watches the vertex, result and register channels, predicts the clipped
// polygon for every accepted vertex and compares each result in order.
// ---------------------------------------------------------------------------
module rpc_checker
    import rpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vert_valid,
    input  logic       vert_ready,
    input  coord_t     vert_x,
    input  coord_t     vert_y,
    input  logic       vert_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  coord_t     out_x,
    input  coord_t     out_y,
    input  logic       out_last,
    input  logic       out_empty,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  coord_t     cfg_data,
    output int         fail_count,
    output int         pending
);

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
        logic   empty;
    } clip_vert_t;

    clip_vert_t clipped_q[$];

    longint bnd_left;
    longint bnd_right;
    longint bnd_bottom;
    longint bnd_top;
    longint first_x[NUM_STAGES];
    longint first_y[NUM_STAGES];
    longint prev_x[NUM_STAGES];
    longint prev_y[NUM_STAGES];
    bit     has_first[NUM_STAGES];
    bit     holding;
    longint held_x;
    longint held_y;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void expect_vertex(longint x, longint y, bit last, bit empty);
        clip_vert_t v;
        v.x     = coord_t'(x);
        v.y     = coord_t'(y);
        v.last  = last;
        v.empty = empty;
        clipped_q.push_back(v);
    endfunction

    function automatic bit is_inside(int s, longint x, longint y);
        case (s)
            0:       return x >= bnd_left;
            1:       return y >= bnd_bottom;
            2:       return x <= bnd_right;
            default: return y <= bnd_top;
        endcase
    endfunction

    // |num| * d / |den|, truncated toward zero, with the ratio clamped to one.
    function automatic longint edge_fraction(longint num, longint den, longint d);
        longint a;
        longint c;
        longint m;
        longint q;
        a = (num < 0) ? -num : num;
        c = (den < 0) ? -den : den;
        m = (d < 0) ? -d : d;
        if (c == 0)
            return 0;
        if (a > c)
            a = c;
        q = (a * m) / c;
        return (d < 0) ? -q : q;
    endfunction

    function automatic void edge_cross(int s, longint px, longint py, longint vx,
                                       longint vy, output longint ix, output longint iy);
        longint b;
        if (s == 0 || s == 2) begin
            b  = (s == 0) ? bnd_left : bnd_right;
            ix = b;
            iy = py + edge_fraction(b - px, vx - px, vy - py);
        end
        else begin
            b  = (s == 1) ? bnd_bottom : bnd_top;
            iy = b;
            ix = px + edge_fraction(b - py, vy - py, vx - px);
        end
    endfunction

    // The newest surviving vertex is held back so that the last flag can go on it.
    function automatic void clip_through(int s, longint x, longint y);
        bit     vin;
        longint ix;
        longint iy;
        if (s >= NUM_STAGES) begin
            if (holding)
                expect_vertex(held_x, held_y, 1'b0, 1'b0);
            held_x  = x;
            held_y  = y;
            holding = 1'b1;
            return;
        end
        vin = is_inside(s, x, y);
        if (!has_first[s]) begin
            has_first[s] = 1'b1;
            first_x[s]   = x;
            first_y[s]   = y;
        end
        else if (is_inside(s, prev_x[s], prev_y[s]) != vin) begin
            edge_cross(s, prev_x[s], prev_y[s], x, y, ix, iy);
            clip_through(s + 1, ix, iy);
        end
        prev_x[s] = x;
        prev_y[s] = y;
        if (vin)
            clip_through(s + 1, x, y);
    endfunction

    function automatic void close_polygon();
        longint ix;
        longint iy;
        for (int s = 0; s < NUM_STAGES; s++) begin
            if (has_first[s] &&
                is_inside(s, prev_x[s], prev_y[s]) != is_inside(s, first_x[s], first_y[s]))
            begin
                edge_cross(s, prev_x[s], prev_y[s], first_x[s], first_y[s], ix, iy);
                clip_through(s + 1, ix, iy);
            end
            has_first[s] = 1'b0;
        end
        if (holding)
            expect_vertex(held_x, held_y, 1'b1, 1'b0);
        else
            expect_vertex(0, 0, 1'b1, 1'b1);
        holding = 1'b0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        clip_vert_t exp_v;
        if (!rst_n) begin
            clipped_q.delete();
            fail_count = 0;
            pending    = 0;
            bnd_left   = 20;
            bnd_right  = 120;
            bnd_bottom = 20;
            bnd_top    = 120;
            holding    = 1'b0;
            for (int s = 0; s < NUM_STAGES; s++)
                has_first[s] = 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LEFT:   bnd_left   = longint'(cfg_data);
                    REG_RIGHT:  bnd_right  = longint'(cfg_data);
                    REG_BOTTOM: bnd_bottom = longint'(cfg_data);
                    REG_TOP:    bnd_top    = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (vert_valid && vert_ready) begin
                clip_through(0, longint'(vert_x), longint'(vert_y));
                if (vert_last)
                    close_polygon();
            end
            if (out_valid && out_ready) begin
                if (clipped_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected vertex (%0d,%0d)", out_x, out_y));
                end
                else begin
                    exp_v = clipped_q.pop_front();
                    if (out_x !== exp_v.x)
                        report_mismatch($sformatf("x %0d, expected %0d", out_x, exp_v.x));
                    if (out_y !== exp_v.y)
                        report_mismatch($sformatf("y %0d, expected %0d", out_y, exp_v.y));
                    if (out_last !== exp_v.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  out_last, exp_v.last));
                    if (out_empty !== exp_v.empty)
                        report_mismatch($sformatf("empty %0b, expected %0b",
                                                  out_empty, exp_v.empty));
                end
            end
            pending = clipped_q.size();
        end
    end

endmodule

// ===== verif/rect_polygon_clipper_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rectangle polygon clipper testbench
// Streams directed and random polygons through several clip rectangles with
// varying back-pressure; a separate checker predicts and compares results.
// ---------------------------------------------------------------------------
module rect_polygon_clipper_test;
    import rpc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic       clk;
    logic       rst_n;
    logic       vert_valid;
    logic       vert_ready;
    coord_t     vert_x;
    coord_t     vert_y;
    logic       vert_last;
    logic       out_valid;
    logic       out_ready;
    coord_t     out_x;
    coord_t     out_y;
    logic       out_last;
    logic       out_empty;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    coord_t     cfg_data;
    int         fail_count;
    int         pending;
    int         cycles = 0;
    int         send_idle_pct;
    int         recv_stall_pct;
    longint     cur_left;
    longint     cur_right;
    longint     cur_bottom;
    longint     cur_top;

    rect_polygon_clipper DUT (.*);

    rpc_checker checker_i (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_vertex(input longint x, input longint y, input bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            vert_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        vert_valid <= 1'b1;
        vert_x     <= coord_t'(x);
        vert_y     <= coord_t'(y);
        vert_last  <= last;
        forever begin
            @(negedge clk);
            if (vert_ready) break;
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= coord_t'(value);
        forever begin
            @(negedge clk);
            if (cfg_ready) break;
        end
        @(posedge clk);
    endtask

    // Stops sending, waits for the last predicted result, then lets the clock run on idle.
    task automatic drain();
        vert_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_bounds(input longint l, input longint r, input longint b,
                              input longint t);
        write_reg(REG_LEFT, l);
        write_reg(REG_RIGHT, r);
        write_reg(REG_BOTTOM, b);
        write_reg(REG_TOP, t);
        cfg_valid  <= 1'b0;
        cur_left   = l;
        cur_right  = r;
        cur_bottom = b;
        cur_top    = t;
    endtask

    function automatic longint pick_coord(longint lo, longint hi);
        longint lo_r;
        longint hi_r;
        longint span;
        longint v;
        if ($urandom_range(99) < 15)
            return longint'(coord_t'($urandom));
        if (lo > hi) begin
            v = lo; lo = hi; hi = v;
        end
        span = (hi - lo) / 2 + 4;
        lo_r = lo - span;
        hi_r = hi + span;
        if (lo_r < -32768) lo_r = -32768;
        if (hi_r > 32767) hi_r = 32767;
        v = lo_r + longint'($urandom_range(32'(hi_r - lo_r)));
        return v;
    endfunction

    task automatic random_polygons(input int vertex_budget, input bit pressure);
        int n;
        int sent;
        sent = 0;
        while (sent < vertex_budget) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
                send_vertex(pick_coord(cur_left, cur_right),
                            pick_coord(cur_bottom, cur_top), i == n - 1);
            sent += n;
            if (pressure && sent > vertex_budget / 2) begin
                vert_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
                pressure = 1'b0;
            end
        end
    endtask

    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        vert_valid     = 1'b0;
        vert_x         = '0;
        vert_y         = '0;
        vert_last      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_LEFT;
        cfg_data       = '0;
        cur_left       = 20;
        cur_right      = 120;
        cur_bottom     = 20;
        cur_top        = 120;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed polygons against the reset rectangle.
        send_vertex(30, 30, 0);   send_vertex(100, 30, 0);  send_vertex(60, 100, 1);
        send_vertex(-100, -100, 0); send_vertex(-50, -100, 0); send_vertex(-80, -50, 1);
        send_vertex(0, 0, 0);     send_vertex(140, 0, 0);
        send_vertex(140, 140, 0); send_vertex(0, 140, 1);
        send_vertex(50, 50, 1);
        send_vertex(0, 0, 1);
        send_vertex(0, 60, 0);    send_vertex(200, 70, 1);
        send_vertex(70, 0, 0);    send_vertex(140, 70, 0);
        send_vertex(70, 140, 0);  send_vertex(0, 70, 1);
        send_vertex(-32768, -32768, 0); send_vertex(32767, -32768, 0);
        send_vertex(32767, 32767, 0);   send_vertex(-32768, 32767, 1);
        send_vertex(20, 20, 0);   send_vertex(120, 20, 0);  send_vertex(120, 120, 1);
        random_polygons(35, 1'b0);
        drain();

        send_idle_pct = 81;
        set_bounds(-32768, 32767, -32768, 32767);
        send_vertex(-32768, 0, 0); send_vertex(32767, -32768, 0); send_vertex(0, 32767, 1);
        random_polygons(35, 1'b1);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 81;
        set_bounds(-500, 300, -200, 700);
        random_polygons(30, 1'b0);
        drain();

        send_idle_pct  = 27;
        recv_stall_pct = 27;
        set_bounds(50, -50, -100, 100);
        random_polygons(25, 1'b0);
        drain();

        set_bounds(0, 0, 0, 0);
        send_vertex(-10, -10, 0); send_vertex(10, -10, 0);
        send_vertex(10, 10, 0);   send_vertex(-10, 10, 1);
        random_polygons(25, 1'b0);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_bounds(-1000, 1000, -30000, 32767);
        random_polygons(30, 1'b0);
        drain();

        send_idle_pct = 81;
        set_bounds(20, 120, 32767, -32768);
        random_polygons(20, 1'b0);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_bounds(-32768, -32768, 32767, 32767);
        random_polygons(20, 1'b0);
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
